[rtl/lpmr_pkg.sv]
// Shared types, codes and header helpers for the length-prefixed message ring.
package lpmr_pkg;

   localparam int RING_DEPTH_DEF = 1024;
   localparam int HEADER_BYTES   = 4;
   localparam int MIN_RING       = 8;
   localparam int CSR_W          = 11;
   localparam int FREE_W         = 11;
   localparam int QUEUE_DEPTH    = 2;   // power of two
   localparam int HP_W           = $clog2(HEADER_BYTES);

   localparam int unsigned HDR_SHIFT [HEADER_BYTES] = '{24, 16, 8, 0};

   typedef logic [2:0] req_code_type;
   localparam req_code_type REQ_SEND_START = 3'd0;
   localparam req_code_type REQ_SEND_BYTE  = 3'd1;
   localparam req_code_type REQ_RECV_START = 3'd2;
   localparam req_code_type REQ_RECV_BYTE  = 3'd3;
   localparam req_code_type REQ_STATUS     = 3'd4;

   typedef logic [2:0] op_type;
   localparam op_type OP_SEND_START = 3'd0;
   localparam op_type OP_SEND_BYTE  = 3'd1;
   localparam op_type OP_RECV_START = 3'd2;
   localparam op_type OP_RECV_BYTE  = 3'd3;
   localparam op_type OP_STATUS     = 3'd4;
   localparam op_type OP_BAD        = 3'd5;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK     = 3'd0;
   localparam status_type ST_NOROOM = 3'd1;
   localparam status_type ST_ZERO   = 3'd2;
   localparam status_type ST_EMPTY  = 3'd3;
   localparam status_type ST_SEQ    = 3'd4;

   typedef struct packed {
      logic        valid;
      op_type      op;
      logic [7:0]  data;
      logic [15:0] len;
   } lpmr_cmd_type;

   // Big-endian header byte at position pos of a 32-bit length word.
   function automatic logic [7:0] header_byte(input logic [15:0] len,
                                              input logic [HP_W-1:0] pos);
      logic [31:0] w;
      w = {16'b0, len};
      return 8'(w >> HDR_SHIFT[pos]);
   endfunction

endpackage

[rtl/lpmr_front.sv]
// Front end: takes request beats, classifies them and queues them for the back end.
module lpmr_front import lpmr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [2:0]   req_type,
   input  logic [7:0]   req_data_in,
   input  logic [15:0]  req_msg_len,
   output logic         busy,
   output lpmr_cmd_type cmd,
   input  logic         cmd_pop
);

   localparam int QP_W = $clog2(QUEUE_DEPTH);
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   lpmr_cmd_type        q_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]     count_ff, count_in;
   logic                accept;
   op_type              op_class;

   always_comb begin
      unique case (req_type)
         REQ_SEND_START: op_class = OP_SEND_START;
         REQ_SEND_BYTE:  op_class = OP_SEND_BYTE;
         REQ_RECV_START: op_class = OP_RECV_START;
         REQ_RECV_BYTE:  op_class = OP_RECV_BYTE;
         REQ_STATUS:     op_class = OP_STATUS;
         default:        op_class = OP_BAD;
      endcase
   end

   assign busy   = (count_ff == QC_W'(QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      wr_ptr_in = accept  ? wr_ptr_ff + QP_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + QP_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QC_W'(accept) - QC_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= '{valid: 1'b1, op: op_class, data: req_data_in,
                              len: req_msg_len};
      end
   end

   always_comb begin
      cmd       = q_ff[rd_ptr_ff];
      cmd.valid = (count_ff != '0);
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != '0)
      else $error("queue popped while empty");

endmodule

[rtl/lpmr_back.sv]
// Back end: ring store, indexes, occupancy and the request sequencer.
module lpmr_back import lpmr_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [CSR_W-1:0]  csr_write_data,
   input  lpmr_cmd_type      cmd,
   output logic              cmd_pop,
   output logic              rsp_strobe,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_data_out,
   output logic [15:0]       rsp_len_out,
   output logic [FREE_W-1:0] rsp_free_bytes,
   output logic              rsp_last_byte
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int CW    = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int FW    = (CNT_W + 1 > 16) ? CNT_W + 1 : 16;
   localparam int HC_W  = $clog2(HEADER_BYTES + 1);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_HDR_WR  = 2'd1;
   localparam logic [1:0] S_HDR_RD  = 2'd2;
   localparam logic [1:0] S_BYTE_RD = 2'd3;

   logic [7:0]       mem [RING_DEPTH];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [7:0]       wr_data;
   logic             wr_en;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] walk_ff, walk_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [15:0]      send_rem_ff, send_rem_in;
   logic [15:0]      recv_rem_ff, recv_rem_in;
   logic [HC_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      hdr_len_ff, hdr_len_in;
   logic             consume_ff, consume_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic [15:0]       rsp_len_ff, rsp_len_in;
   logic [FREE_W-1:0] rsp_free_ff, rsp_free_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [FW-1:0]     free_now, free_next;
   logic [15:0]       hdr_word;

   function automatic logic [CNT_W-1:0] clamp_size(input logic [CSR_W-1:0] v);
      logic [CW-1:0] w;
      w = CW'(v);
      if (w < CW'(MIN_RING)) return CNT_W'(MIN_RING);
      else if (w > CW'(RING_DEPTH)) return CNT_W'(RING_DEPTH);
      else return CNT_W'(w);
   endfunction

   function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] idx,
                                             input logic [CNT_W-1:0] sz);
      logic [CNT_W-1:0] n;
      n = CNT_W'(idx) + CNT_W'(1);
      return (n >= sz) ? '0 : IDX_W'(n);
   endfunction

   // Payload room: size minus used minus header, floored at zero.
   function automatic logic [FW-1:0] free_of(input logic [CNT_W-1:0] used,
                                             input logic [CNT_W-1:0] sz);
      logic [FW-1:0] u4;
      logic [FW-1:0] s;
      u4 = FW'(used) + FW'(HEADER_BYTES);
      s  = FW'(sz);
      return (u4 >= s) ? '0 : s - u4;
   endfunction

   assign free_now = free_of(used_ff, size_ff);
   assign hdr_word = {len_ff[7:0], rd_data_ff};
   assign rd_addr  = (state_ff == S_IDLE) ? rd_idx_ff : walk_ff;

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      walk_in       = walk_ff;
      used_in       = used_ff;
      size_in       = size_ff;
      send_rem_in   = send_rem_ff;
      recv_rem_in   = recv_rem_ff;
      cnt_in        = cnt_ff;
      len_in        = len_ff;
      hdr_len_in    = hdr_len_ff;
      consume_in    = consume_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = wr_idx_ff;
      wr_data       = cmd.data;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_data_in   = '0;
      rsp_len_in    = '0;
      rsp_last_in   = 1'b0;

      if (csr_write_en) begin
         // resize empties the ring and drops any open transfer
         size_in     = clamp_size(csr_write_data);
         state_in    = S_IDLE;
         rd_idx_in   = '0;
         wr_idx_in   = '0;
         used_in     = '0;
         send_rem_in = '0;
         recv_rem_in = '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.valid) begin
                  cmd_pop = 1'b1;
                  unique case (cmd.op)
                     OP_SEND_START: begin
                        if (send_rem_ff != '0) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_SEQ;
                        end else if (cmd.len == '0) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_ZERO;
                        end else if (FW'(cmd.len) > free_now) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_NOROOM;
                        end else begin
                           hdr_len_in  = cmd.len;
                           send_rem_in = cmd.len;
                           cnt_in      = '0;
                           state_in    = S_HDR_WR;
                        end
                     end
                     OP_SEND_BYTE: begin
                        rsp_strobe_in = 1'b1;
                        if (send_rem_ff == '0) begin
                           rsp_status_in = ST_SEQ;
                        end else begin
                           wr_en       = 1'b1;
                           wr_idx_in   = bump(wr_idx_ff, size_ff);
                           used_in     = used_ff + CNT_W'(1);
                           send_rem_in = send_rem_ff - 16'd1;
                           rsp_last_in = (send_rem_ff == 16'd1);
                        end
                     end
                     OP_RECV_START: begin
                        if (recv_rem_ff != '0) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_SEQ;
                        end else if (used_ff < CNT_W'(HEADER_BYTES)) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_EMPTY;
                        end else begin
                           walk_in    = rd_idx_ff;
                           cnt_in     = '0;
                           consume_in = 1'b1;
                           state_in   = S_HDR_RD;
                        end
                     end
                     OP_RECV_BYTE: begin
                        if (recv_rem_ff == '0) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_SEQ;
                        end else if (used_ff == '0) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_EMPTY;
                        end else begin
                           // read issues now, data lands next cycle
                           rd_idx_in   = bump(rd_idx_ff, size_ff);
                           used_in     = used_ff - CNT_W'(1);
                           recv_rem_in = recv_rem_ff - 16'd1;
                           state_in    = S_BYTE_RD;
                        end
                     end
                     OP_STATUS: begin
                        if (recv_rem_ff == '0 && used_ff >= CNT_W'(HEADER_BYTES)) begin
                           walk_in    = rd_idx_ff;
                           cnt_in     = '0;
                           consume_in = 1'b0;
                           state_in   = S_HDR_RD;
                        end else begin
                           rsp_strobe_in = 1'b1;
                        end
                     end
                     default: begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_SEQ;
                     end
                  endcase
               end
            end
            S_HDR_WR: begin
               wr_en     = 1'b1;
               wr_data   = header_byte(hdr_len_ff, cnt_ff[HP_W-1:0]);
               wr_idx_in = bump(wr_idx_ff, size_ff);
               used_in   = used_ff + CNT_W'(1);
               cnt_in    = cnt_ff + HC_W'(1);
               if (cnt_ff == HC_W'(HEADER_BYTES - 1)) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            end
            S_HDR_RD: begin
               // walk the header; shift in each byte in the cycle after its read
               if (cnt_ff != HC_W'(HEADER_BYTES)) begin
                  walk_in = bump(walk_ff, size_ff);
               end
               if (cnt_ff != '0) begin
                  len_in = hdr_word;
               end
               cnt_in = cnt_ff + HC_W'(1);
               if (cnt_ff == HC_W'(HEADER_BYTES)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_len_in    = hdr_word;
                  state_in      = S_IDLE;
                  if (consume_ff) begin
                     rd_idx_in   = walk_ff;
                     used_in     = used_ff - CNT_W'(HEADER_BYTES);
                     recv_rem_in = hdr_word;
                  end
               end
            end
            S_BYTE_RD: begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = rd_data_ff;
               rsp_last_in   = (recv_rem_ff == '0);
               state_in      = S_IDLE;
            end
            default: state_in = S_IDLE;
         endcase
      end

      free_next   = free_of(used_in, size_in);
      rsp_free_in = free_next[FREE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_idx_ff     <= '0;
         wr_idx_ff     <= '0;
         used_ff       <= '0;
         size_ff       <= clamp_size(CSR_W'(1024));
         send_rem_ff   <= '0;
         recv_rem_ff   <= '0;
         cnt_ff        <= '0;
         consume_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         wr_idx_ff     <= wr_idx_in;
         used_ff       <= used_in;
         size_ff       <= size_in;
         send_rem_ff   <= send_rem_in;
         recv_rem_ff   <= recv_rem_in;
         cnt_ff        <= cnt_in;
         consume_ff    <= consume_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      len_ff        <= len_in;
      hdr_len_ff    <= hdr_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_len_out    = rsp_len_ff;
   assign rsp_free_bytes = rsp_free_ff;
   assign rsp_last_byte  = rsp_last_ff;

   a_used_fits: assert property (@(posedge clock) disable iff (reset)
      used_ff <= size_ff)
      else $error("occupancy above ring size");

   a_wr_idx_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(wr_idx_ff) < size_ff)
      else $error("write index outside ring");

   a_hdr_wr_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HDR_WR |-> send_rem_ff != '0)
      else $error("header write without open send");

   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_ff |-> rsp_status_ff == ST_OK)
      else $error("last byte flagged on failed beat");

endmodule

[rtl/length_prefixed_message_ring_unit.sv]
// Top level of the length-prefixed message ring: request queue and ring engine.
// The engine takes one request at a time, its pace set by the ring memory moving
// one byte per cycle on its write or read port; a 2-beat queue takes further requests
// meanwhile until it is full.
// Results are strobed for one cycle and cannot be held off.
// Synchronous reset empties the ring and sets the size to 1024 (capped at depth).
module length_prefixed_message_ring_unit import lpmr_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_type,
   input  logic [7:0]        req_data_in,
   input  logic [15:0]       req_msg_len,
   output logic              rsp_strobe,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_data_out,
   output logic [15:0]       rsp_len_out,
   output logic [FREE_W-1:0] rsp_free_bytes,
   output logic              rsp_last_byte,
   input  logic              csr_write_en,
   input  logic [CSR_W-1:0]  csr_write_data
);

   lpmr_cmd_type cmd;
   logic         cmd_pop;

   lpmr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_type    (req_type),
      .req_data_in (req_data_in),
      .req_msg_len (req_msg_len),
      .busy        (busy),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   lpmr_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_len_out    (rsp_len_out),
      .rsp_free_bytes (rsp_free_bytes),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
